[rtl/prj_pkg.sv]
// shared types and constants for the parallactic rotation pipeline
// no dependencies
package prj_pkg;

  localparam int DATA_W        = 16;
  localparam int FRAC_BITS_DEF = 15;
  localparam int UNIT_BITS     = 30;
  localparam int RAD_W         = 64;
  localparam int ROOT_W        = 32;
  localparam int VEC_W         = 33;
  localparam int UNIT_W        = 32;
  localparam int SHIFT_W       = 5;
  localparam int SQ_LANES      = 2;
  localparam int DIV_LANES     = 5;

  // configuration register indexes
  localparam logic [1:0] REG_NORMAL_X = 2'd0;
  localparam logic [1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [1:0] REG_NORMAL_Z = 2'd2;

  // divider lane order
  localparam int LN_U1X = 0;
  localparam int LN_U1Y = 1;
  localparam int LN_U2X = 2;
  localparam int LN_U2Y = 3;
  localparam int LN_U2Z = 4;

  typedef struct packed {
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W-1:0] dz;
    logic                     deg;
  } dir_t;

  typedef struct packed {
    logic signed [DATA_W:0]  ax;
    logic signed [DATA_W:0]  ay;
    logic signed [VEC_W-1:0] bx;
    logic signed [VEC_W-1:0] by;
    logic signed [VEC_W-1:0] bz;
    logic [SHIFT_W-1:0]      h1;
    logic [SHIFT_W-1:0]      h2;
    dir_t                    dir;
  } geom_t;

endpackage

[rtl/prj_front.sv]
// front end: cross products, squared lengths and even normalizing shift
// depends on prj_pkg
module prj_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [prj_pkg::DATA_W-1:0] dir_x,
  input  logic signed [prj_pkg::DATA_W-1:0] dir_y,
  input  logic signed [prj_pkg::DATA_W-1:0] dir_z,
  input  logic signed [prj_pkg::DATA_W-1:0] nrm_x,
  input  logic signed [prj_pkg::DATA_W-1:0] nrm_y,
  input  logic signed [prj_pkg::DATA_W-1:0] nrm_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output prj_pkg::geom_t                    out_geom,
  output logic [prj_pkg::RAD_W-1:0]         out_rad1,
  output logic [prj_pkg::RAD_W-1:0]         out_rad2
);
  import prj_pkg::*;

  localparam int NORM_STG = SHIFT_W;
  localparam int STAGES   = 4 + NORM_STG;

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES:0]   rdy;

  // stall chain: a stage takes new data when empty or moving on
  assign rdy[STAGES] = out_ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign vld_nxt   = {vld_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) vld_r[i] <= vld_nxt[i];
      end
    end
  end

  // stage 0: partial products of normal cross direction
  logic signed [2*DATA_W-1:0] p_zy_r, p_yz_r, p_xz_r, p_zx_r, p_yx_r, p_xy_r;
  logic signed [DATA_W-1:0]   dx0_r, dy0_r, dz0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      p_zy_r <= dir_z * nrm_y;
      p_yz_r <= dir_y * nrm_z;
      p_xz_r <= dir_x * nrm_z;
      p_zx_r <= dir_z * nrm_x;
      p_yx_r <= dir_y * nrm_x;
      p_xy_r <= dir_x * nrm_y;
      dx0_r  <= dir_x;
      dy0_r  <= dir_y;
      dz0_r  <= dir_z;
    end
  end

  // stage 1: cross product components
  geom_t gm1_nxt, gm1_r;

  always_comb begin
    gm1_nxt         = '0;
    gm1_nxt.ax      = -(17'(dy0_r));
    gm1_nxt.ay      = 17'(dx0_r);
    gm1_nxt.bx      = 33'(p_zy_r) - 33'(p_yz_r);
    gm1_nxt.by      = 33'(p_xz_r) - 33'(p_zx_r);
    gm1_nxt.bz      = 33'(p_yx_r) - 33'(p_xy_r);
    gm1_nxt.dir.dx  = dx0_r;
    gm1_nxt.dir.dy  = dy0_r;
    gm1_nxt.dir.dz  = dz0_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) gm1_r <= gm1_nxt;
  end

  // stage 2: squares
  logic signed [2*DATA_W+1:0] sq_ax, sq_ay;
  logic signed [2*VEC_W-1:0]  sq_bx, sq_by, sq_bz;
  logic [RAD_W-1:0]           sq_ax_r, sq_ay_r, sq_bx_r, sq_by_r, sq_bz_r;
  geom_t                      gm2_r;

  assign sq_ax = gm1_r.ax * gm1_r.ax;
  assign sq_ay = gm1_r.ay * gm1_r.ay;
  assign sq_bx = gm1_r.bx * gm1_r.bx;
  assign sq_by = gm1_r.by * gm1_r.by;
  assign sq_bz = gm1_r.bz * gm1_r.bz;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sq_ax_r <= RAD_W'(unsigned'(sq_ax));
      sq_ay_r <= RAD_W'(unsigned'(sq_ay));
      sq_bx_r <= sq_bx[RAD_W-1:0];
      sq_by_r <= sq_by[RAD_W-1:0];
      sq_bz_r <= sq_bz[RAD_W-1:0];
      gm2_r   <= gm1_r;
    end
  end

  // stage 3: squared lengths
  logic [RAD_W-1:0] s1_r, s2_r;
  geom_t            gm3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s1_r  <= sq_ax_r + sq_ay_r;
      s2_r  <= sq_bx_r + sq_by_r + sq_bz_r;
      gm3_r <= gm2_r;
    end
  end

  // normalizing stages: shift by 2*SH bits while the top bits are zero
  logic [RAD_W-1:0] ns1_r [NORM_STG];
  logic [RAD_W-1:0] ns2_r [NORM_STG];
  geom_t            ngm_r [NORM_STG];

  for (genvar j = 0; j < NORM_STG; j++) begin : g_norm
    localparam int SH = 1 << (NORM_STG - 1 - j);
    logic [RAD_W-1:0] s1_in, s2_in, s1_nxt, s2_nxt;
    geom_t            gm_in, gm_nxt;

    if (j == 0) begin : g_first
      assign s1_in = s1_r;
      assign s2_in = s2_r;
      always_comb begin
        gm_in         = gm3_r;
        gm_in.dir.deg = (s1_r == '0) || (s2_r == '0);
      end
    end else begin : g_rest
      assign s1_in = ns1_r[j-1];
      assign s2_in = ns2_r[j-1];
      assign gm_in = ngm_r[j-1];
    end

    always_comb begin
      gm_nxt = gm_in;
      s1_nxt = s1_in;
      s2_nxt = s2_in;
      if (s1_in[RAD_W-1 -: 2*SH] == '0) begin
        s1_nxt    = s1_in << (2*SH);
        gm_nxt.h1 = gm_in.h1 | SHIFT_W'(SH);
      end
      if (s2_in[RAD_W-1 -: 2*SH] == '0) begin
        s2_nxt    = s2_in << (2*SH);
        gm_nxt.h2 = gm_in.h2 | SHIFT_W'(SH);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[4+j]) begin
        ns1_r[j] <= s1_nxt;
        ns2_r[j] <= s2_nxt;
        ngm_r[j] <= gm_nxt;
      end
    end
  end

  assign out_geom = ngm_r[NORM_STG-1];
  assign out_rad1 = ns1_r[NORM_STG-1];
  assign out_rad2 = ns2_r[NORM_STG-1];

endmodule

[rtl/prj_sqrt.sv]
// pipelined integer square root, two digits per stage, several lanes
// depends on prj_pkg
module prj_sqrt #(
  parameter int LANES  = prj_pkg::SQ_LANES,
  parameter int SIDE_W = $bits(prj_pkg::geom_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [prj_pkg::RAD_W-1:0]  in_rad [LANES],
  input  logic [SIDE_W-1:0]          in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [prj_pkg::ROOT_W-1:0] out_root [LANES],
  output logic [SIDE_W-1:0]          out_side
);
  import prj_pkg::*;

  localparam int PER    = 2;
  localparam int STAGES = ROOT_W / PER;

  typedef struct packed {
    logic [RAD_W-1:0] x;
    logic [RAD_W-1:0] r;
  } sq_t;

  // one digit of the bitwise root recurrence
  function automatic sq_t sq_step(sq_t a, logic [RAD_W-1:0] b);
    logic [RAD_W:0] t;
    sq_t            o;
    t = {1'b0, a.r} + {1'b0, b};
    if ({1'b0, a.x} >= t) begin
      o.x = a.x - t[RAD_W-1:0];
      o.r = (a.r >> 1) + b;
    end else begin
      o.x = a.x;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic logic [ROOT_W-1:0] res_out(sq_t a);
    return a.r[ROOT_W-1:0];
  endfunction

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES:0]   rdy;

  assign rdy[STAGES] = out_ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign vld_nxt   = {vld_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) vld_r[i] <= vld_nxt[i];
      end
    end
  end

  sq_t               st_r   [STAGES][LANES];
  logic [SIDE_W-1:0] side_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stg
    localparam logic [RAD_W-1:0] B0 = RAD_W'(1) << (RAD_W - 2 - 2*PER*g);
    localparam logic [RAD_W-1:0] B1 = RAD_W'(1) << (RAD_W - 4 - 2*PER*g);
    logic [SIDE_W-1:0] side_in;

    if (g == 0) begin : g_first_side
      assign side_in = in_side;
    end else begin : g_rest_side
      assign side_in = side_r[g-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      sq_t a_in, res;
      if (g == 0) begin : g_first
        assign a_in = '{x: in_rad[l], r: '0};
      end else begin : g_rest
        assign a_in = st_r[g-1][l];
      end
      assign res = sq_step(sq_step(a_in, B0), B1);

      always_ff @(posedge clk) begin
        if (rdy[g]) st_r[g][l] <= res;
      end
      if (g == STAGES - 1) begin : g_out
        assign out_root[l] = res_out(st_r[g][l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) side_r[g] <= side_in;
    end
  end

  assign out_side = side_r[STAGES-1];

endmodule

[rtl/prj_div.sv]
// pipelined restoring divider giving rounded signed unit components
// depends on prj_pkg
module prj_div #(
  parameter int LANES  = prj_pkg::DIV_LANES,
  parameter int SIDE_W = $bits(prj_pkg::dir_t)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [prj_pkg::VEC_W-1:0]  in_vec   [LANES],
  input  logic [prj_pkg::SHIFT_W-1:0]       in_shift [LANES],
  input  logic [prj_pkg::ROOT_W-1:0]        in_den   [LANES],
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [prj_pkg::UNIT_W-1:0] out_unit [LANES],
  output logic [SIDE_W-1:0]                 out_side
);
  import prj_pkg::*;

  localparam int QBITS    = UNIT_BITS + 2;
  localparam int PER      = 2;
  localparam int STEP_STG = QBITS / PER;
  localparam int STAGES   = STEP_STG + 2;

  typedef struct packed {
    logic [ROOT_W:0]   r;
    logic [QBITS-1:0]  q;
    logic [ROOT_W-1:0] n;
    logic              neg;
  } dv_t;

  // one quotient bit; the first bit compares the bare numerator
  function automatic dv_t dv_step(dv_t a, logic first);
    dv_t o;
    o   = a;
    o.q = {a.q[QBITS-2:0], 1'b0};
    if (!first) o.r = {a.r[ROOT_W-1:0], 1'b0};
    if (o.r >= {1'b0, a.n}) begin
      o.r    = o.r - {1'b0, a.n};
      o.q[0] = 1'b1;
    end
    return o;
  endfunction

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES:0]   rdy;

  assign rdy[STAGES] = out_ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign vld_nxt   = {vld_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) vld_r[i] <= vld_nxt[i];
      end
    end
  end

  dv_t                       st_r   [STEP_STG+1][LANES];
  logic [SIDE_W-1:0]         side_r [STAGES];
  logic signed [UNIT_W-1:0]  unit_r [LANES];

  // side data delay line
  always_ff @(posedge clk) begin
    for (int i = 0; i < STAGES; i++) begin
      if (rdy[i]) side_r[i] <= (i == 0) ? in_side : side_r[(i == 0) ? 0 : i-1];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // prep stage: magnitude scaled by the normalizing shift
    logic [VEC_W-1:0] mag;
    logic [RAD_W-1:0] num_w;
    dv_t              prep;

    assign mag   = in_vec[l][VEC_W-1] ? VEC_W'(-in_vec[l]) : VEC_W'(in_vec[l]);
    assign num_w = RAD_W'(mag) << in_shift[l];
    always_comb begin
      prep     = '0;
      prep.r   = num_w[ROOT_W:0];
      prep.n   = in_den[l];
      prep.neg = in_vec[l][VEC_W-1];
    end

    always_ff @(posedge clk) begin
      if (rdy[0]) st_r[0][l] <= prep;
    end

    // quotient stages
    for (genvar g = 0; g < STEP_STG; g++) begin : g_stg
      dv_t res;
      assign res = dv_step(dv_step(st_r[g][l], (g == 0)), 1'b0);
      always_ff @(posedge clk) begin
        if (rdy[g+1]) st_r[g+1][l] <= res;
      end
    end

    // round half up on the magnitude and restore the sign
    logic [QBITS:0]        rsum;
    logic [UNIT_W-1:0]     rq;
    logic signed [UNIT_W-1:0] u_nxt;

    assign rsum  = {1'b0, st_r[STEP_STG][l].q} + (QBITS+1)'(1);
    assign rq    = rsum[UNIT_W:1];
    assign u_nxt = st_r[STEP_STG][l].neg ? -signed'(rq) : signed'(rq);

    always_ff @(posedge clk) begin
      if (rdy[STAGES-1]) unit_r[l] <= u_nxt;
    end

    assign out_unit[l] = unit_r[l];
  end

  assign out_side = side_r[STAGES-1];

endmodule

[rtl/prj_rot.sv]
// back end: dot and triple products, rounding, saturation, result register
// depends on prj_pkg
module prj_rot #(
  parameter int FRAC_BITS = prj_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [prj_pkg::UNIT_W-1:0] in_unit [prj_pkg::DIV_LANES],
  input  prj_pkg::dir_t                     in_dir,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [prj_pkg::DATA_W-1:0] jones_xx,
  output logic signed [prj_pkg::DATA_W-1:0] jones_xy,
  output logic signed [prj_pkg::DATA_W-1:0] jones_yx,
  output logic signed [prj_pkg::DATA_W-1:0] jones_yy,
  output logic                              degenerate
);
  import prj_pkg::*;

  localparam int STAGES = 8;
  localparam int PW     = 2*UNIT_W;
  localparam int COS_SH = 2*UNIT_BITS - FRAC_BITS;
  localparam int COS_W  = FRAC_BITS + 3;
  localparam int CR_W   = UNIT_BITS + 3;
  localparam int SP_W   = CR_W + DATA_W;
  localparam int SA_W   = SP_W + 2;
  localparam logic [PW-1:0]   COS_HALF = PW'(1) << (COS_SH - 1);
  localparam logic [PW-1:0]   CR_HALF  = PW'(1) << (UNIT_BITS - 1);
  localparam logic [SA_W-1:0] SIN_HALF = SA_W'(1) << (UNIT_BITS - 1);
  localparam logic signed [PW-1:0] MAX16 = PW'((1 << (DATA_W-1)) - 1);
  localparam logic signed [PW-1:0] MIN16 = -PW'(1 << (DATA_W-1));

  function automatic logic signed [DATA_W-1:0] sat16(logic signed [PW-1:0] v);
    if (v > MAX16) return DATA_W'(MAX16);
    if (v < MIN16) return DATA_W'(MIN16);
    return v[DATA_W-1:0];
  endfunction

  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES:0]   rdy;

  assign rdy[STAGES] = out_ready;
  for (genvar i = 0; i < STAGES; i++) begin : g_rdy
    assign rdy[i] = !vld_r[i] || rdy[i+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[STAGES-1];
  assign vld_nxt   = {vld_r[STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (rdy[i]) vld_r[i] <= vld_nxt[i];
      end
    end
  end

  // stage 0: pairwise products of the unit vectors
  logic signed [PW-1:0] pcc0_r, pcc1_r, px_r, py_r, pz0_r, pz1_r;
  dir_t                 dir0_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pcc0_r <= in_unit[LN_U1X] * in_unit[LN_U2X];
      pcc1_r <= in_unit[LN_U1Y] * in_unit[LN_U2Y];
      px_r   <= in_unit[LN_U1Y] * in_unit[LN_U2Z];
      py_r   <= in_unit[LN_U1X] * in_unit[LN_U2Z];
      pz0_r  <= in_unit[LN_U1X] * in_unit[LN_U2Y];
      pz1_r  <= in_unit[LN_U1Y] * in_unit[LN_U2X];
      dir0_r <= in_dir;
    end
  end

  // stage 1: dot product and cross product sums
  logic signed [PW-1:0] cacc_r, vx_r, vy_r, vz_r;
  dir_t                 dir1_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cacc_r <= pcc0_r + pcc1_r;
      vx_r   <= px_r;
      vy_r   <= -py_r;
      vz_r   <= pz0_r - pz1_r;
      dir1_r <= dir0_r;
    end
  end

  // stage 2: magnitude plus rounding half
  logic [PW-1:0] mc_r, mx_r, my_r, mz_r;
  logic          nc_r, nx_r, ny_r, nz_r;
  dir_t          dir2_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      mc_r   <= (cacc_r[PW-1] ? PW'(-cacc_r) : PW'(cacc_r)) + COS_HALF;
      mx_r   <= (vx_r[PW-1] ? PW'(-vx_r) : PW'(vx_r)) + CR_HALF;
      my_r   <= (vy_r[PW-1] ? PW'(-vy_r) : PW'(vy_r)) + CR_HALF;
      mz_r   <= (vz_r[PW-1] ? PW'(-vz_r) : PW'(vz_r)) + CR_HALF;
      nc_r   <= cacc_r[PW-1];
      nx_r   <= vx_r[PW-1];
      ny_r   <= vy_r[PW-1];
      nz_r   <= vz_r[PW-1];
      dir2_r <= dir1_r;
    end
  end

  // stage 3: shift down and restore sign
  logic [PW-1:0]           tc, tx, ty, tz;
  logic signed [PW-1:0]    c_nxt, x_nxt, y_nxt, z_nxt;
  logic signed [COS_W-1:0] c_r;
  logic signed [CR_W-1:0]  cx_r, cy_r, cz_r;
  dir_t                    dir3_r;

  assign tc    = mc_r >> COS_SH;
  assign tx    = mx_r >> UNIT_BITS;
  assign ty    = my_r >> UNIT_BITS;
  assign tz    = mz_r >> UNIT_BITS;
  assign c_nxt = nc_r ? -signed'(tc) : signed'(tc);
  assign x_nxt = nx_r ? -signed'(tx) : signed'(tx);
  assign y_nxt = ny_r ? -signed'(ty) : signed'(ty);
  assign z_nxt = nz_r ? -signed'(tz) : signed'(tz);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      c_r    <= c_nxt[COS_W-1:0];
      cx_r   <= x_nxt[CR_W-1:0];
      cy_r   <= y_nxt[CR_W-1:0];
      cz_r   <= z_nxt[CR_W-1:0];
      dir3_r <= dir2_r;
    end
  end

  // stage 4: triple product terms, saturated cosine
  logic signed [SP_W-1:0]   sx_r, sy_r, sz_r;
  logic signed [DATA_W-1:0] jxx4_r, jyy4_r;
  logic signed [PW-1:0]     c_w;
  dir_t                     dir4_r;

  assign c_w = PW'(c_r);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      sx_r   <= cx_r * dir3_r.dx;
      sy_r   <= cy_r * dir3_r.dy;
      sz_r   <= cz_r * dir3_r.dz;
      jxx4_r <= sat16(-c_w);
      jyy4_r <= sat16(c_w);
      dir4_r <= dir3_r;
    end
  end

  // stage 5: triple product sum
  logic signed [SA_W-1:0]   sacc_r;
  logic signed [DATA_W-1:0] jxx5_r, jyy5_r;
  logic                     deg5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      sacc_r <= SA_W'(sx_r) + SA_W'(sy_r) + SA_W'(sz_r);
      jxx5_r <= jxx4_r;
      jyy5_r <= jyy4_r;
      deg5_r <= dir4_r.deg;
    end
  end

  // stage 6: sine magnitude plus rounding half
  logic [SA_W-1:0]          ms_r;
  logic                     ns_r;
  logic signed [DATA_W-1:0] jxx6_r, jyy6_r;
  logic                     deg6_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      ms_r   <= (sacc_r[SA_W-1] ? SA_W'(-sacc_r) : SA_W'(sacc_r)) + SIN_HALF;
      ns_r   <= sacc_r[SA_W-1];
      jxx6_r <= jxx5_r;
      jyy6_r <= jyy5_r;
      deg6_r <= deg5_r;
    end
  end

  // stage 7: result register, zeroed for a degenerate geometry
  logic [SA_W-1:0]          ts;
  logic signed [PW-1:0]     s_w;
  logic signed [DATA_W-1:0] s16;
  logic signed [DATA_W-1:0] jxx_r, jxy_r, jyy_r;
  logic                     deg_r;

  assign ts  = ms_r >> UNIT_BITS;
  assign s_w = ns_r ? -signed'(PW'(ts)) : signed'(PW'(ts));
  assign s16 = sat16(s_w);

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      jxx_r <= deg6_r ? '0 : jxx6_r;
      jxy_r <= deg6_r ? '0 : s16;
      jyy_r <= deg6_r ? '0 : jyy6_r;
      deg_r <= deg6_r;
    end
  end

  assign jones_xx   = jxx_r;
  assign jones_xy   = jxy_r;
  assign jones_yx   = jxy_r;
  assign jones_yy   = jyy_r;
  assign degenerate = deg_r;

endmodule

[rtl/parallactic_rotation_jones.sv]
// parallactic rotation matrix from a source direction and a field normal
// one request per cycle sustained while out_stall is low,
// set by the fully pipelined root (16 stages) and divider (18 stages)
// stall backs up stage by stage; empty stages still take new requests
// synchronous active-low reset clears pipeline valids and sets the normal to +z
// depends on prj_pkg, prj_front, prj_sqrt, prj_div, prj_rot
module parallactic_rotation_jones #(
  parameter int FRAC_BITS = prj_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [prj_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [prj_pkg::DATA_W-1:0] in_dir_x,
  input  logic signed [prj_pkg::DATA_W-1:0] in_dir_y,
  input  logic signed [prj_pkg::DATA_W-1:0] in_dir_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [prj_pkg::DATA_W-1:0] out_jones_xx,
  output logic signed [prj_pkg::DATA_W-1:0] out_jones_xy,
  output logic signed [prj_pkg::DATA_W-1:0] out_jones_yx,
  output logic signed [prj_pkg::DATA_W-1:0] out_jones_yy,
  output logic                              out_degenerate
);
  import prj_pkg::*;

  localparam int GEOM_W = $bits(geom_t);
  localparam int DIR_W  = $bits(dir_t);
  localparam logic [DATA_W-1:0] NZ_RESET = DATA_W'((1 << (DATA_W-1)) - 1);

  // field normal registers
  logic signed [DATA_W-1:0] nrm_x_r, nrm_y_r, nrm_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_x_r <= '0;
      nrm_y_r <= '0;
      nrm_z_r <= NZ_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NORMAL_X: nrm_x_r <= cfg_data;
        REG_NORMAL_Y: nrm_y_r <= cfg_data;
        REG_NORMAL_Z: nrm_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // front end
  logic             fr_in_ready, fr_valid, sq_in_ready;
  geom_t            fr_geom;
  logic [RAD_W-1:0] fr_rad1, fr_rad2;

  prj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (fr_in_ready),
    .dir_x     (in_dir_x),
    .dir_y     (in_dir_y),
    .dir_z     (in_dir_z),
    .nrm_x     (nrm_x_r),
    .nrm_y     (nrm_y_r),
    .nrm_z     (nrm_z_r),
    .out_valid (fr_valid),
    .out_ready (sq_in_ready),
    .out_geom  (fr_geom),
    .out_rad1  (fr_rad1),
    .out_rad2  (fr_rad2)
  );

  assign in_stall = !fr_in_ready;

  // square roots of both squared lengths
  logic [RAD_W-1:0]  sq_rad  [SQ_LANES];
  logic [ROOT_W-1:0] sq_root [SQ_LANES];
  logic [GEOM_W-1:0] sq_side;
  logic              sq_valid, dv_in_ready;
  geom_t             sq_geom;

  assign sq_rad[0] = fr_rad1;
  assign sq_rad[1] = fr_rad2;

  prj_sqrt #(
    .LANES  (SQ_LANES),
    .SIDE_W (GEOM_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (sq_in_ready),
    .in_rad    (sq_rad),
    .in_side   (fr_geom),
    .out_valid (sq_valid),
    .out_ready (dv_in_ready),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign sq_geom = geom_t'(sq_side);

  // unit vector components
  logic signed [VEC_W-1:0]  dv_vec   [DIV_LANES];
  logic [SHIFT_W-1:0]       dv_shift [DIV_LANES];
  logic [ROOT_W-1:0]        dv_den   [DIV_LANES];
  logic signed [UNIT_W-1:0] dv_unit  [DIV_LANES];
  logic [DIR_W-1:0]         dv_side;
  logic                     dv_valid, rot_in_ready;

  assign dv_vec[LN_U1X]   = VEC_W'(sq_geom.ax);
  assign dv_vec[LN_U1Y]   = VEC_W'(sq_geom.ay);
  assign dv_vec[LN_U2X]   = sq_geom.bx;
  assign dv_vec[LN_U2Y]   = sq_geom.by;
  assign dv_vec[LN_U2Z]   = sq_geom.bz;
  assign dv_shift[LN_U1X] = sq_geom.h1;
  assign dv_shift[LN_U1Y] = sq_geom.h1;
  assign dv_shift[LN_U2X] = sq_geom.h2;
  assign dv_shift[LN_U2Y] = sq_geom.h2;
  assign dv_shift[LN_U2Z] = sq_geom.h2;
  assign dv_den[LN_U1X]   = sq_root[0];
  assign dv_den[LN_U1Y]   = sq_root[0];
  assign dv_den[LN_U2X]   = sq_root[1];
  assign dv_den[LN_U2Y]   = sq_root[1];
  assign dv_den[LN_U2Z]   = sq_root[1];

  prj_div #(
    .LANES  (DIV_LANES),
    .SIDE_W (DIR_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (dv_in_ready),
    .in_vec    (dv_vec),
    .in_shift  (dv_shift),
    .in_den    (dv_den),
    .in_side   (sq_geom.dir),
    .out_valid (dv_valid),
    .out_ready (rot_in_ready),
    .out_unit  (dv_unit),
    .out_side  (dv_side)
  );

  // angle and output matrix
  prj_rot #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rot (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (dv_valid),
    .in_ready   (rot_in_ready),
    .in_unit    (dv_unit),
    .in_dir     (dir_t'(dv_side)),
    .out_valid  (out_valid),
    .out_ready  (!out_stall),
    .jones_xx   (out_jones_xx),
    .jones_xy   (out_jones_xy),
    .jones_yx   (out_jones_yx),
    .jones_yy   (out_jones_yy),
    .degenerate (out_degenerate)
  );

endmodule
